[rtl/core/mpq_pkg.sv]
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared constants, types and helpers for the multilevel priority run queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int TASK_ID_BITS = 16;
   localparam int NUM_QUEUES   = 3;
   localparam int PRIO_BITS    = 8;

   localparam int Q_W     = $clog2(NUM_QUEUES);
   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W  = $clog2(NUM_QUEUES * QUEUE_DEPTH);
   localparam int ENTRY_W = TASK_ID_BITS + PRIO_BITS;

   localparam logic [0:0] OP_INSERT   = 1'b0;
   localparam logic [0:0] OP_DISPATCH = 1'b1;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

   function automatic logic [ADDR_W-1:0] queue_addr(input logic [Q_W-1:0]   q,
                                                    input logic [IDX_W-1:0] idx);
      return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx);
   endfunction

endpackage

`default_nettype wire

[rtl/core/multilevel_priority_run_queue_unit.sv]
// ----------------------------------------------------------------------------
// multilevel_priority_run_queue_unit
// Three run queues with insert and most-urgent dispatch.
// ----------------------------------------------------------------------------
// An insert, and a dispatch that finds all queues empty, never raise busy:
// the result strobes in the cycle after start and a new beat may follow at
// once. A dispatch keeps busy high while it scans its queue and moves up
// the entries behind the pick, and strobes its result in the first cycle
// with busy low. Its duration is set by the single read port of the entry
// RAM: one entry is read per cycle into the compare unit during the scan,
// then one per cycle while the entries behind the pick move up one place.
// rsp_valid is high for exactly one cycle per beat and cannot be held off;
// the receiver must take it then.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_priority_run_queue_unit
   import mpq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [15:0] req_task_id,
   input  wire logic [7:0]  req_priority_req,
   input  wire logic [1:0]  req_queue_select,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_out_task_id,
   output logic [7:0]       rsp_out_priority,
   output logic [1:0]       rsp_out_queue
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_PREP  = 2'd2;
   localparam logic [1:0] S_SHIFT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0] count_ff [NUM_QUEUES];
   logic [CNT_W-1:0] count_in [NUM_QUEUES];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic [7:0]  rsp_prio_ff, rsp_prio_in;
   logic [1:0]  rsp_queue_ff, rsp_queue_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_wa;
   logic [ENTRY_W-1:0] ram_wd;
   logic [ADDR_W-1:0] ram_ra;
   logic [ENTRY_W-1:0] ram_rd;

   scan_ctl_type            scan_ctl;
   logic [TASK_ID_BITS-1:0] best_id;
   logic [PRIO_BITS-1:0]    best_prio;
   logic [IDX_W-1:0]        best_idx;

   logic             ins_valid_q;
   logic [CNT_W-1:0] ins_cnt;
   logic             sel_found;
   logic [Q_W-1:0]   sel_q;

   mpq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(NUM_QUEUES * QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   mpq_scan u_scan (
      .clock    (clock),
      .ctl      (scan_ctl),
      .entry    (ram_rd),
      .best_id  (best_id),
      .best_prio(best_prio),
      .best_idx (best_idx)
   );

   always_comb begin
      ins_valid_q = 1'b0;
      ins_cnt     = '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         if (req_queue_select == 2'(i)) begin
            ins_valid_q = 1'b1;
            ins_cnt     = count_ff[i];
         end
      end
   end

   always_comb begin
      sel_found = 1'b0;
      sel_q     = '0;
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            sel_found = 1'b1;
            sel_q     = Q_W'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      q_in          = q_ff;
      n_in          = n_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_queue_in  = rsp_queue_ff;
      ram_we        = 1'b0;
      ram_wa        = '0;
      ram_wd        = '0;
      ram_ra        = '0;
      scan_ctl      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_id_in    = '0;
               rsp_prio_in  = '0;
               rsp_queue_in = '0;
               if (req_op == OP_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (ins_valid_q && (ins_cnt < CNT_W'(QUEUE_DEPTH))) begin
                     ram_we = 1'b1;
                     ram_wa = queue_addr(Q_W'(req_queue_select), IDX_W'(ins_cnt));
                     ram_wd = {TASK_ID_BITS'(req_task_id), req_priority_req};
                     count_in[Q_W'(req_queue_select)] = ins_cnt + 1'b1;
                     rsp_status_in = STATUS_DONE;
                  end else begin
                     rsp_status_in = STATUS_DROPPED;
                  end
               end else if (sel_found) begin
                  q_in      = sel_q;
                  n_in      = count_ff[sel_q];
                  ram_ra    = queue_addr(sel_q, '0);
                  rd_idx_in = CNT_W'(1);
                  state_in  = S_SCAN;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
               end
            end
         end
         S_SCAN: begin
            scan_ctl.valid = 1'b1;
            scan_ctl.first = (rd_idx_ff == CNT_W'(1));
            scan_ctl.idx   = IDX_W'(rd_idx_ff - 1'b1);
            if (rd_idx_ff < n_ff) begin
               ram_ra    = queue_addr(q_ff, IDX_W'(rd_idx_ff));
               rd_idx_in = rd_idx_ff + 1'b1;
            end else begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if ((CNT_W'(best_idx) + 1'b1) < n_ff) begin
               ram_ra    = queue_addr(q_ff, IDX_W'(CNT_W'(best_idx) + 1'b1));
               wr_idx_in = best_idx;
               state_in  = S_SHIFT;
            end
         end
         S_SHIFT: begin
            ram_we = 1'b1;
            ram_wa = queue_addr(q_ff, wr_idx_ff);
            ram_wd = ram_rd;
            if ((CNT_W'(wr_idx_ff) + CNT_W'(2)) < n_ff) begin
               ram_ra    = queue_addr(q_ff, IDX_W'(CNT_W'(wr_idx_ff) + CNT_W'(2)));
               wr_idx_in = wr_idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // finish the dispatch: drop the pick from its queue and report it
      if (((state_ff == S_PREP) && (state_in == S_PREP)) ||
          ((state_ff == S_SHIFT) && (wr_idx_in == wr_idx_ff))) begin
         state_in       = S_IDLE;
         count_in[q_ff] = n_ff - 1'b1;
         rsp_valid_in   = 1'b1;
         rsp_status_in  = STATUS_DONE;
         rsp_id_in      = 16'(best_id);
         rsp_prio_in    = best_prio;
         rsp_queue_in   = 2'(q_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      n_ff          <= n_in;
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_queue_ff  <= rsp_queue_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_task_id  = rsp_id_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_out_queue    = rsp_queue_ff;

endmodule

`default_nettype wire

[rtl/core/mpq_ram.sv]
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/mpq_scan.sv]
// ----------------------------------------------------------------------------
// mpq_scan
// Shared compare unit: tracks the most urgent entry seen during a queue scan.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_scan
   import mpq_pkg::*;
(
   input  wire logic                    clock,
   input  wire scan_ctl_type            ctl,
   input  wire logic [ENTRY_W-1:0]      entry,
   output logic      [TASK_ID_BITS-1:0] best_id,
   output logic      [PRIO_BITS-1:0]    best_prio,
   output logic      [IDX_W-1:0]        best_idx
);

   logic [TASK_ID_BITS-1:0] best_id_ff;
   logic [PRIO_BITS-1:0]    best_prio_ff;
   logic [IDX_W-1:0]        best_idx_ff;
   logic [PRIO_BITS-1:0]    entry_prio;
   logic                    take;

   assign entry_prio = entry[PRIO_BITS-1:0];
   assign take = ctl.valid && (ctl.first || (entry_prio < best_prio_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_id_ff   <= entry[ENTRY_W-1:PRIO_BITS];
         best_prio_ff <= entry_prio;
         best_idx_ff  <= ctl.idx;
      end
   end

   assign best_id   = best_id_ff;
   assign best_prio = best_prio_ff;
   assign best_idx  = best_idx_ff;

endmodule

`default_nettype wire

[tb/multilevel_priority_run_queue_unit_tb.sv]
// ----------------------------------------------------------------------------
// multilevel_priority_run_queue_unit_tb
// Self-checking bench for the three-level priority run queue.
//
// Inserts and dispatches go in through the start/busy command port. Gaps
// between bursts are random. Each accepted beat is run through a local model
// of the three queues at the edge where it is taken. The expected outcome is
// then queued and compared field by field with the next rsp_valid strobe.
// The run starts with hand-picked cases: empty dispatch, bad queue select,
// field extremes, ties and removal from the middle. Random rounds then fill
// every queue past capacity and drain it. A long random mix follows, with
// shifting insert/dispatch balance and narrow priority ranges that force ties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multilevel_priority_run_queue_unit_tb;
   import mpq_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] task_id;
      logic [7:0]  prio;
      logic [1:0]  queue;
   } outcome_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_op;
   logic [15:0] req_task_id;
   logic [7:0]  req_priority_req;
   logic [1:0]  req_queue_select;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_task_id;
   logic [7:0]  rsp_out_priority;
   logic [1:0]  rsp_out_queue;

   logic [15:0] ready_id   [NUM_QUEUES][QUEUE_DEPTH];
   logic [7:0]  ready_prio [NUM_QUEUES][QUEUE_DEPTH];
   int          ready_count[NUM_QUEUES];

   outcome_t awaited_outcomes[$];
   int       error_count;
   int       burst_left;
   int       n_inserted;
   int       n_dropped;
   int       n_dispatched;
   int       n_empty;

   multilevel_priority_run_queue_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .req_queue_select (req_queue_select),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_task_id  (rsp_out_task_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_queue    (rsp_out_queue)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("%0t: timeout, %0d results still awaited", $time, awaited_outcomes.size());
      $display("end of test: mismatches");
      $finish;
   end

   function automatic outcome_t schedule_outcome(input logic op, input logic [15:0] id,
                                                 input logic [7:0] prio,
                                                 input logic [1:0] qsel);
      outcome_t res;
      int       best;
      res = '0;
      res.status = STATUS_DONE;
      if (op == OP_INSERT) begin
         if (qsel >= NUM_QUEUES || ready_count[qsel] >= QUEUE_DEPTH) begin
            res.status = STATUS_DROPPED;
            n_dropped++;
         end else begin
            ready_id[qsel][ready_count[qsel]]   = id;
            ready_prio[qsel][ready_count[qsel]] = prio;
            ready_count[qsel]++;
            n_inserted++;
         end
         return res;
      end
      for (int q = 0; q < NUM_QUEUES; q++) begin
         if (ready_count[q] != 0) begin
            best = 0;
            for (int i = 1; i < ready_count[q]; i++)
               if (ready_prio[q][i] < ready_prio[q][best]) best = i;
            res.task_id = ready_id[q][best];
            res.prio    = ready_prio[q][best];
            res.queue   = 2'(q);
            for (int i = best; i + 1 < ready_count[q]; i++) begin
               ready_id[q][i]   = ready_id[q][i + 1];
               ready_prio[q][i] = ready_prio[q][i + 1];
            end
            ready_count[q]--;
            n_dispatched++;
            return res;
         end
      end
      res.status = STATUS_EMPTY;
      n_empty++;
      return res;
   endfunction

   // hold the beat until an edge with busy low takes it
   task automatic send_beat(input logic op, input logic [15:0] id, input logic [7:0] prio,
                            input logic [1:0] qsel);
      req_op           <= op;
      req_task_id      <= id;
      req_priority_req <= prio;
      req_queue_select <= qsel;
      start            <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      awaited_outcomes.push_back(schedule_outcome(op, id, prio, qsel));
   endtask

   task automatic send_paced(input logic op, input logic [15:0] id, input logic [7:0] prio,
                             input logic [1:0] qsel);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_beat(op, id, prio, qsel);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (awaited_outcomes.size() != 0);
   endtask

   function automatic int queued_total();
      return ready_count[0] + ready_count[1] + ready_count[2];
   endfunction

   task automatic test_directed_cases();
      send_paced(OP_DISPATCH, 16'hFFFF, 8'hFF, 2'd3);
      send_paced(OP_INSERT, 16'h0001, 8'd1, 2'd3);
      send_paced(OP_INSERT, 16'hFFFF, 8'hFF, 2'd3);
      send_paced(OP_INSERT, 16'hFFFF, 8'hFF, 2'd2);
      send_paced(OP_INSERT, 16'h0000, 8'd0, 2'd1);
      send_paced(OP_INSERT, 16'h1234, 8'd0, 2'd1);
      send_paced(OP_INSERT, 16'h00FF, 8'd139, 2'd0);
      send_paced(OP_INSERT, 16'h8000, 8'd7, 2'd0);
      send_paced(OP_INSERT, 16'h8001, 8'd7, 2'd0);
      send_paced(OP_INSERT, 16'h8002, 8'd200, 2'd0);
      repeat (8) send_paced(OP_DISPATCH, 16'($urandom), 8'($urandom), 2'($urandom));
      send_paced(OP_INSERT, 16'hA000, 8'd9, 2'd0);
      send_paced(OP_INSERT, 16'hA001, 8'd3, 2'd0);
      send_paced(OP_INSERT, 16'hA002, 8'd9, 2'd0);
      send_paced(OP_INSERT, 16'hA003, 8'd9, 2'd0);
      repeat (3) send_paced(OP_DISPATCH, 16'h5555, 8'hAA, 2'd1);
   endtask

   task automatic test_fill_to_capacity();
      logic       narrow;
      logic [7:0] prio;
      for (int round = 0; round < 3; round++) begin
         narrow = round[0];
         while (ready_count[0] < QUEUE_DEPTH || ready_count[1] < QUEUE_DEPTH ||
                ready_count[2] < QUEUE_DEPTH) begin
            prio = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
            send_paced(OP_INSERT, 16'($urandom), prio, 2'($urandom_range(0, 3)));
         end
         repeat (3) send_paced(OP_INSERT, 16'($urandom), 8'($urandom), 2'($urandom));
         while (queued_total() != 0)
            send_paced(OP_DISPATCH, 16'($urandom), 8'($urandom), 2'($urandom));
         send_paced(OP_DISPATCH, 16'($urandom), 8'($urandom), 2'($urandom));
      end
   endtask

   task automatic test_random_mix();
      int         insert_pct;
      logic       narrow;
      logic       op;
      logic [1:0] qsel;
      logic [7:0] prio;
      for (int seg = 0; seg < 16; seg++) begin
         case ($urandom_range(0, 2))
            0: begin
               insert_pct = 85;
            end
            1: begin
               insert_pct = 50;
            end
            default: begin
               insert_pct = 20;
            end
         endcase
         narrow = 1'($urandom);
         for (int i = 0; i < 50; i++) begin
            op   = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DISPATCH;
            qsel = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            prio = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
            send_paced(op, 16'($urandom), prio, qsel);
         end
         if (seg % 5 == 4) drain_results();
      end
   endtask

   always @(posedge clock) begin
      outcome_t want;
      if (!reset && rsp_valid) begin
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: unexpected result, status %0d id %h prio %0d queue %0d", $time,
                     rsp_status, rsp_out_task_id, rsp_out_priority, rsp_out_queue);
            error_count++;
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               error_count++;
            end
            if (rsp_out_task_id !== want.task_id) begin
               $display("%0t: task id expected %h actual %h", $time, want.task_id,
                        rsp_out_task_id);
               error_count++;
            end
            if (rsp_out_priority !== want.prio) begin
               $display("%0t: priority expected %0d actual %0d", $time, want.prio,
                        rsp_out_priority);
               error_count++;
            end
            if (rsp_out_queue !== want.queue) begin
               $display("%0t: queue expected %0d actual %0d", $time, want.queue,
                        rsp_out_queue);
               error_count++;
            end
         end
      end
   end

   initial begin
      error_count  = 0;
      burst_left   = 0;
      n_inserted   = 0;
      n_dropped    = 0;
      n_dispatched = 0;
      n_empty      = 0;
      for (int q = 0; q < NUM_QUEUES; q++) ready_count[q] = 0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_op           <= OP_INSERT;
      req_task_id      <= 16'h0;
      req_priority_req <= 8'h0;
      req_queue_select <= 2'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      drain_results();
      test_fill_to_capacity();
      drain_results();
      test_random_mix();
      drain_results();
      repeat (2 * QUEUE_DEPTH + 8) @(posedge clock);
      $display("Covered %0d accepted inserts and %0d dropped ones (full queue or bad select),",
               n_inserted, n_dropped);
      $display("%0d dispatches that found a task and %0d that found all queues empty.",
               n_dispatched, n_empty);
      if (error_count == 0 && awaited_outcomes.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
